// ===== rtl/mfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mfe_pkg
// Types, codes, constants and helper functions of the frame encoder.
// ----------------------------------------------------------------------------
package mfe_pkg;

	localparam int ACT_W = 2;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [ACT_W-1:0] ACT_BYTE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LAST = 2'd1;
	localparam logic [ACT_W-1:0] ACT_END  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd3;

	localparam logic        RST_FRAME_MODE    = 1'b0;
	localparam logic [7:0]  RST_SLAVE_ADDRESS = 8'h01;
	localparam logic [7:0]  RST_FUNCTION_CODE = 8'h03;
	localparam logic [15:0] RST_START_ADDRESS = 16'h0000;

	localparam logic [7:0]  CHAR_STX   = 8'h02;
	localparam logic [7:0]  CHAR_COLON = 8'h3A;
	localparam logic [7:0]  CHAR_CR    = 8'h0D;
	localparam logic [7:0]  CHAR_LF    = 8'h0A;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;

	localparam logic [1:0] HDR_LAST_IDX   = 2'd3;
	localparam logic [1:0] TRL_LAST_ASCII = 2'd3;
	localparam logic [1:0] TRL_LAST_BIN   = 2'd1;

	typedef struct packed {
		logic             has_byte;
		logic             ends;
		logic [BYTE_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic        frame_mode;
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
		logic [15:0] start_address;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_NEW,
		PH_STX,
		PH_COLON,
		PH_HDR,
		PH_DATA,
		PH_TRL
	} phase_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
	endfunction

endpackage

// ===== rtl/mfe_front.sv =====
// ----------------------------------------------------------------------------
// mfe_front
// Input side: takes items, sorts them by action and drops unused codes.
// ----------------------------------------------------------------------------
module mfe_front (
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [mfe_pkg::BYTE_W-1:0] s_axis_tdata,   // data_byte
	input  logic [mfe_pkg::ACT_W-1:0]  s_axis_tuser,   // action
	input  logic                       queue_full,
	output logic                       push,
	output mfe_pkg::item_t             item
);

	logic keep;

	always_comb begin
		item.data = s_axis_tdata;
		item.has_byte = 1'b0;
		item.ends = 1'b0;
		keep = 1'b1;
		case (s_axis_tuser)
			mfe_pkg::ACT_BYTE: item.has_byte = 1'b1;
			mfe_pkg::ACT_LAST: begin
				item.has_byte = 1'b1;
				item.ends = 1'b1;
			end
			mfe_pkg::ACT_END: item.ends = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign s_axis_tready = !queue_full;
	assign push = s_axis_tvalid && !queue_full && keep;

endmodule

// ===== rtl/mfe_queue.sv =====
// ----------------------------------------------------------------------------
// mfe_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module mfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfe_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output mfe_pkg::item_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mfe_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mfe_back.sv =====
// ----------------------------------------------------------------------------
// mfe_back
// Output sequencer: expands each queued item into header, payload and
// trailer bytes, keeps the running CRC and LRC, drives the output register.
// ----------------------------------------------------------------------------
module mfe_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mfe_pkg::cfg_t              cfg,
	input  logic                       head_valid,
	input  mfe_pkg::item_t             head,
	output logic                       pop,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [mfe_pkg::BYTE_W-1:0] m_axis_tdata,   // out_byte
	output logic                       m_axis_tlast
);

	mfe_pkg::phase_t phase_q, phase_d, first_ph, ph;
	logic [1:0]  idx_q, idx_d;
	logic        nib_q, nib_d;
	logic        hdr_sent_q;
	logic [15:0] crc_q;
	logic [7:0]  lrc_q, lrc_neg, cur_byte, char_d;
	logic        ascii, fire, byte_done, acc, hdr_done, frame_end, last_d;
	logic [1:0]  trl_last;
	logic        out_valid_q, out_last_q;
	logic [7:0]  out_data_q;

	assign ascii = cfg.frame_mode;
	assign fire = head_valid && (!out_valid_q || m_axis_tready);
	assign byte_done = !ascii || nib_q;
	assign trl_last = ascii ? mfe_pkg::TRL_LAST_ASCII : mfe_pkg::TRL_LAST_BIN;
	assign lrc_neg = 8'h00 - lrc_q;

	always_comb begin
		if (!hdr_sent_q) begin
			first_ph = ascii ? mfe_pkg::PH_STX : mfe_pkg::PH_HDR;
		end else begin
			first_ph = head.has_byte ? mfe_pkg::PH_DATA : mfe_pkg::PH_TRL;
		end
		ph = (phase_q == mfe_pkg::PH_NEW) ? first_ph : phase_q;
	end

	always_comb begin
		cur_byte = head.data;
		if (ph == mfe_pkg::PH_HDR) begin
			case (idx_q)
				2'd0: cur_byte = cfg.slave_address;
				2'd1: cur_byte = cfg.function_code;
				2'd2: cur_byte = cfg.start_address[15:8];
				default: cur_byte = cfg.start_address[7:0];
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		nib_d = nib_q;
		pop = 1'b0;
		hdr_done = 1'b0;
		frame_end = 1'b0;
		if (fire) begin
			case (ph)
				mfe_pkg::PH_STX: phase_d = mfe_pkg::PH_COLON;
				mfe_pkg::PH_COLON: begin
					phase_d = mfe_pkg::PH_HDR;
					idx_d = 2'd0;
					nib_d = 1'b0;
				end
				mfe_pkg::PH_HDR: begin
					if (byte_done) begin
						nib_d = 1'b0;
						if (idx_q == mfe_pkg::HDR_LAST_IDX) begin
							idx_d = 2'd0;
							hdr_done = 1'b1;
							phase_d = head.has_byte ? mfe_pkg::PH_DATA : mfe_pkg::PH_TRL;
						end else begin
							idx_d = idx_q + 2'd1;
							phase_d = mfe_pkg::PH_HDR;
						end
					end else begin
						nib_d = 1'b1;
						phase_d = mfe_pkg::PH_HDR;
					end
				end
				mfe_pkg::PH_DATA: begin
					if (byte_done) begin
						nib_d = 1'b0;
						idx_d = 2'd0;
						if (head.ends) begin
							phase_d = mfe_pkg::PH_TRL;
						end else begin
							phase_d = mfe_pkg::PH_NEW;
							pop = 1'b1;
						end
					end else begin
						nib_d = 1'b1;
						phase_d = mfe_pkg::PH_DATA;
					end
				end
				mfe_pkg::PH_TRL: begin
					if (idx_q == trl_last) begin
						phase_d = mfe_pkg::PH_NEW;
						idx_d = 2'd0;
						nib_d = 1'b0;
						pop = 1'b1;
						frame_end = 1'b1;
					end else begin
						idx_d = idx_q + 2'd1;
						phase_d = mfe_pkg::PH_TRL;
					end
				end
				default: phase_d = mfe_pkg::PH_NEW;
			endcase
		end
	end

	// outputs
	always_comb begin
		char_d = 8'h00;
		last_d = 1'b0;
		case (ph)
			mfe_pkg::PH_STX: char_d = mfe_pkg::CHAR_STX;
			mfe_pkg::PH_COLON: char_d = mfe_pkg::CHAR_COLON;
			mfe_pkg::PH_HDR, mfe_pkg::PH_DATA: begin
				if (ascii) begin
					char_d = mfe_pkg::hex_char(nib_q ? cur_byte[3:0] : cur_byte[7:4]);
				end else begin
					char_d = cur_byte;
				end
			end
			mfe_pkg::PH_TRL: begin
				if (ascii) begin
					case (idx_q)
						2'd0: char_d = mfe_pkg::hex_char(lrc_neg[7:4]);
						2'd1: char_d = mfe_pkg::hex_char(lrc_neg[3:0]);
						2'd2: char_d = mfe_pkg::CHAR_CR;
						default: begin
							char_d = mfe_pkg::CHAR_LF;
							last_d = 1'b1;
						end
					endcase
				end else begin
					char_d = idx_q[0] ? crc_q[15:8] : crc_q[7:0];
					last_d = idx_q[0];
				end
			end
			default: char_d = 8'h00;
		endcase
	end

	assign acc = fire && (ph == mfe_pkg::PH_HDR || ph == mfe_pkg::PH_DATA)
		&& (!ascii || !nib_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mfe_pkg::PH_NEW;
			idx_q <= 2'd0;
			nib_q <= 1'b0;
			hdr_sent_q <= 1'b0;
			crc_q <= mfe_pkg::CRC_INIT;
			lrc_q <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			nib_q <= nib_d;
			if (frame_end) begin
				hdr_sent_q <= 1'b0;
				crc_q <= mfe_pkg::CRC_INIT;
				lrc_q <= 8'h00;
			end else begin
				if (hdr_done) begin
					hdr_sent_q <= 1'b1;
				end
				if (acc) begin
					crc_q <= mfe_pkg::crc_update(crc_q, cur_byte);
					lrc_q <= lrc_q + cur_byte;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= char_d;
			out_last_q <= last_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tlast = out_last_q;

endmodule

// ===== rtl/modbus_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// modbus_frame_encoder
// Modbus request frame encoder, binary with CRC-16 or ASCII hex with LRC.
// ----------------------------------------------------------------------------
// Usage: write frame_mode, slave_address, function_code and start_address
// through the cfg channel (index 0 to 3) while the block is idle. Payload
// items arrive on s_axis: tdata carries the byte, tuser the action (0 byte,
// 1 last byte, 2 end of frame with no byte; 3 is dropped). Frame bytes or
// characters leave on m_axis, one per cycle while the receiver is ready
// and items are queued, tlast on the final one. The header goes out ahead
// of the first item of a frame, the trailer after the item that ends it.
// An accepted item is registered in the queue, and its first output then
// in the single output register. A payload item yields one byte in binary
// mode and two characters in ASCII mode, the header four bytes (binary) or
// ten characters (ASCII), the trailer two bytes or four characters.
// A queue of QUEUE_DEPTH items lets the input run ahead of the output.
// Reset restores the register defaults and starts a new frame. When the
// receiver stalls the output holds and the queue fills, then s_axis_tready
// drops.
// ----------------------------------------------------------------------------
module modbus_frame_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [mfe_pkg::BYTE_W-1:0]     s_axis_tdata,   // data_byte
	input  logic [mfe_pkg::ACT_W-1:0]      s_axis_tuser,   // action
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [mfe_pkg::BYTE_W-1:0]     m_axis_tdata,   // out_byte
	output logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mfe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfe_pkg::CFG_DATA_W-1:0] cfg_data
);

	mfe_pkg::cfg_t  cfg_q;
	mfe_pkg::item_t push_item, head;
	logic push, pop, full, head_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_mode <= mfe_pkg::RST_FRAME_MODE;
			cfg_q.slave_address <= mfe_pkg::RST_SLAVE_ADDRESS;
			cfg_q.function_code <= mfe_pkg::RST_FUNCTION_CODE;
			cfg_q.start_address <= mfe_pkg::RST_START_ADDRESS;
		end else if (cfg_valid) begin
			case (cfg_index)
				mfe_pkg::REG_FRAME_MODE: cfg_q.frame_mode <= cfg_data[0];
				mfe_pkg::REG_SLAVE_ADDRESS: cfg_q.slave_address <= cfg_data[7:0];
				mfe_pkg::REG_FUNCTION_CODE: cfg_q.function_code <= cfg_data[7:0];
				mfe_pkg::REG_START_ADDRESS: cfg_q.start_address <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	mfe_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.queue_full    (full),
		.push          (push),
		.item          (push_item)
	);

	mfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	mfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== tb/tb_modbus_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_modbus_frame_encoder
// Self-checking bench for the Modbus frame encoder. A short directed table
// covers reset defaults, register extremes, ASCII and binary framing, empty
// frames, the dropped action, a zero LRC and mode changes inside an open
// frame. Random frames follow under random source and sink stalls. Every
// output byte is checked by a behavioural bench encoder or the plan table.
// ----------------------------------------------------------------------------
module tb_modbus_frame_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mfe_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [7:0] STX = mfe_pkg::CHAR_STX;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASES = 20;
	localparam int ITEMS_PER_PHASE = 19;
	localparam int N_STEPS = 32;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} tx_byte_t;

	typedef struct packed {
		logic                           is_cfg;
		logic [mfe_pkg::CFG_IDX_W-1:0]  idx;
		logic [mfe_pkg::CFG_DATA_W-1:0] val;
		logic [mfe_pkg::ACT_W-1:0]      act;
		logic [7:0]                     dat;
		logic                           typed;
		logic [7:0]                     first;
	} step_t;

	localparam step_t PLAN [0:N_STEPS-1] = '{
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_END, 8'h00, 1'b1, 8'h01},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'h00, 1'b1, 8'h01},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, ACT_UNUSED, 8'hFF, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'hFF, 1'b1, 8'hFF},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_LAST, 8'h5A, 1'b1, 8'h5A},
		'{1'b1, mfe_pkg::REG_FRAME_MODE, 16'h0001, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_LAST, 8'hAB, 1'b1, STX},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_END, 8'hFF, 1'b1, STX},
		'{1'b1, mfe_pkg::REG_SLAVE_ADDRESS, 16'h00FF, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b1, mfe_pkg::REG_FUNCTION_CODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b1, mfe_pkg::REG_START_ADDRESS, 16'hFFFF, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'h0F, 1'b1, STX},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'hF0, 1'b1, 8'h46},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_LAST, 8'h00, 1'b1, 8'h30},
		'{1'b1, mfe_pkg::REG_FUNCTION_CODE, 16'h0001, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b1, mfe_pkg::REG_START_ADDRESS, 16'h0000, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_END, 8'h00, 1'b1, STX},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'h12, 1'b1, STX},
		'{1'b1, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_LAST, 8'h34, 1'b1, 8'h34},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'h77, 1'b1, 8'hFF},
		'{1'b1, mfe_pkg::REG_FRAME_MODE, 16'h0001, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_END, 8'h00, 1'b0, 8'h00},
		'{1'b1, mfe_pkg::REG_START_ADDRESS, 16'h1234, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, ACT_UNUSED, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_LAST, 8'hC3, 1'b1, STX},
		'{1'b1, mfe_pkg::REG_SLAVE_ADDRESS, 16'h0000, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b1, mfe_pkg::REG_FUNCTION_CODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b1, mfe_pkg::REG_START_ADDRESS, 16'h0000, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_END, 8'h00, 1'b1, STX},
		'{1'b1, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_BYTE, 8'h00, 1'b0, 8'h00},
		'{1'b0, mfe_pkg::REG_FRAME_MODE, 16'h0000, mfe_pkg::ACT_LAST, 8'h80, 1'b1, 8'h00}
	};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [mfe_pkg::BYTE_W-1:0]     s_axis_tdata = '0;
	logic [mfe_pkg::ACT_W-1:0]      s_axis_tuser = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b1;
	logic [mfe_pkg::BYTE_W-1:0]     m_axis_tdata;
	logic                           m_axis_tlast;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [mfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	mfe_pkg::cfg_t cfg_shadow;
	logic          hdr_open;
	logic [15:0]   crc_run;
	logic [7:0]    lrc_run;
	tx_byte_t      item_bytes[$];
	tx_byte_t      bytes_due[$];
	int            fail_count = 0;
	bit            steady = 1'b0;

	modbus_frame_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // data_byte
		.s_axis_tuser  (s_axis_tuser),   // action
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // out_byte
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
	endfunction

	function automatic void emit_raw(input logic [7:0] b, input logic fin);
		item_bytes.push_back('{b, fin});
	endfunction

	function automatic void emit_field(input logic [7:0] b);
		crc_run = crc_run ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			crc_run = crc_run[0] ? ((crc_run >> 1) ^ mfe_pkg::CRC_POLY) : (crc_run >> 1);
		end
		lrc_run = lrc_run + b;
		if (cfg_shadow.frame_mode) begin
			emit_raw(nibble_char(b[7:4]), 1'b0);
			emit_raw(nibble_char(b[3:0]), 1'b0);
		end else begin
			emit_raw(b, 1'b0);
		end
	endfunction

	function automatic void encode_item(input logic [mfe_pkg::ACT_W-1:0] act,
			input logic [7:0] dat);
		logic [7:0] lrc;
		item_bytes.delete();
		if (act == ACT_UNUSED)
			return;
		if (!hdr_open) begin
			if (cfg_shadow.frame_mode) begin
				emit_raw(mfe_pkg::CHAR_STX, 1'b0);
				emit_raw(mfe_pkg::CHAR_COLON, 1'b0);
			end
			emit_field(cfg_shadow.slave_address);
			emit_field(cfg_shadow.function_code);
			emit_field(cfg_shadow.start_address[15:8]);
			emit_field(cfg_shadow.start_address[7:0]);
			hdr_open = 1'b1;
		end
		if (act == mfe_pkg::ACT_BYTE || act == mfe_pkg::ACT_LAST)
			emit_field(dat);
		if (act == mfe_pkg::ACT_LAST || act == mfe_pkg::ACT_END) begin
			if (cfg_shadow.frame_mode) begin
				lrc = 8'h00 - lrc_run;
				emit_raw(nibble_char(lrc[7:4]), 1'b0);
				emit_raw(nibble_char(lrc[3:0]), 1'b0);
				emit_raw(mfe_pkg::CHAR_CR, 1'b0);
				emit_raw(mfe_pkg::CHAR_LF, 1'b1);
			end else begin
				emit_raw(crc_run[7:0], 1'b0);
				emit_raw(crc_run[15:8], 1'b1);
			end
			hdr_open = 1'b0;
			crc_run = mfe_pkg::CRC_INIT;
			lrc_run = 8'h00;
		end
	endfunction

	task automatic send_item(input logic [mfe_pkg::ACT_W-1:0] act, input logic [7:0] dat,
			input logic typed, input logic [7:0] first);
		while (!steady && $urandom_range(0, 99) < 11) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= dat;
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		encode_item(act, dat);
		if (typed && item_bytes.size() > 0)
			item_bytes[0].out_byte = first;
		foreach (item_bytes[i])
			bytes_due.push_back(item_bytes[i]);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mfe_pkg::CFG_IDX_W-1:0] idx,
			input logic [mfe_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			mfe_pkg::REG_FRAME_MODE:    cfg_shadow.frame_mode = val[0];
			mfe_pkg::REG_SLAVE_ADDRESS: cfg_shadow.slave_address = val[7:0];
			mfe_pkg::REG_FUNCTION_CODE: cfg_shadow.function_code = val[7:0];
			mfe_pkg::REG_START_ADDRESS: cfg_shadow.start_address = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sink stalls
	always @(negedge clk)
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);

	always @(posedge clk) begin
		tx_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (bytes_due.size() == 0) begin
				$error("out_byte expected none got %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = bytes_due.pop_front();
				if (m_axis_tdata !== want.out_byte) begin
					$error("out_byte expected %h got %h", want.out_byte, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last expected %b got %b", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int sent;
		int len;
		int pick;
		logic [mfe_pkg::CFG_IDX_W-1:0] idx;
		logic [mfe_pkg::CFG_DATA_W-1:0] top;
		logic [mfe_pkg::CFG_DATA_W-1:0] val;

		cfg_shadow.frame_mode = mfe_pkg::RST_FRAME_MODE;
		cfg_shadow.slave_address = mfe_pkg::RST_SLAVE_ADDRESS;
		cfg_shadow.function_code = mfe_pkg::RST_FUNCTION_CODE;
		cfg_shadow.start_address = mfe_pkg::RST_START_ADDRESS;
		hdr_open = 1'b0;
		crc_run = mfe_pkg::CRC_INIT;
		lrc_run = 8'h00;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int s = 0; s < N_STEPS; s++) begin
			if (PLAN[s].is_cfg) begin
				wait_idle();
				write_reg(PLAN[s].idx, PLAN[s].val);
			end else begin
				send_item(PLAN[s].act, PLAN[s].dat, PLAN[s].typed, PLAN[s].first);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			steady = (ph >= 8 && ph < 11);
			repeat ($urandom_range(1, 3)) begin
				idx = 2'($urandom_range(0, 3));
				top = (idx == mfe_pkg::REG_FRAME_MODE) ? 16'h0001 :
					(idx == mfe_pkg::REG_START_ADDRESS) ? 16'hFFFF : 16'h00FF;
				pick = $urandom_range(0, 3);
				val = (pick == 0) ? 16'h0000 : (pick == 1) ? top :
					16'($urandom_range(0, top));
				write_reg(idx, val);
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				len = $urandom_range(0, 5);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 99) < 8)
						send_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
					send_item(mfe_pkg::ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
					sent++;
				end
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					send_item(mfe_pkg::ACT_LAST, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
					sent++;
				end else if (pick < 90) begin
					send_item(mfe_pkg::ACT_END, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
					sent++;
				end
			end
		end
		steady = 1'b0;

		wait_idle();
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mfe_pkg.sv
rtl/mfe_front.sv
rtl/mfe_queue.sv
rtl/mfe_back.sv
rtl/modbus_frame_encoder.sv
tb/tb_modbus_frame_encoder.sv
